[hw/rtl/tnst_pkg.sv]
// Shared types and constants for the top-N sorted tracker.
package tnst_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int FUNC_W = 2;
   localparam int RESP_W = 32;
   localparam int RANK_W = 6;
   localparam int LIMIT_W = 7;
   localparam int COUNT_W = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_CLEAR  = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

endpackage

[hw/rtl/tnst_ifs.sv]
// Request and response channel interfaces of the top-N sorted tracker.
interface tnst_req_if;
   logic                               valid;
   logic                               ready;
   logic [tnst_pkg::FUNC_W-1:0]        func;
   logic signed [tnst_pkg::RESP_W-1:0] response;
   logic [tnst_pkg::RANK_W-1:0]        rank_index;

   modport source (output valid, output func, output response, output rank_index,
                   input ready);
   modport sink (input valid, input func, input response, input rank_index,
                 output ready);
endinterface

interface tnst_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               kept;
   logic [tnst_pkg::COUNT_W-1:0]       entry_count;
   logic signed [tnst_pkg::RESP_W-1:0] smallest_kept;
   logic signed [tnst_pkg::RESP_W-1:0] read_value;
   logic                               read_valid;

   modport source (output valid, output kept, output entry_count, output smallest_kept,
                   output read_value, output read_valid, input ready);
   modport sink (input valid, input kept, input entry_count, input smallest_kept,
                 input read_value, input read_valid, output ready);
endinterface

[hw/rtl/tnst_cell.sv]
// One compare-and-shift cell of the sorted table.
module tnst_cell (
   input  logic                               clock,
   input  logic                               shift_en,
   input  logic signed [tnst_pkg::RESP_W-1:0] new_value,
   input  logic                               cell_valid,
   input  logic                               left_stay,
   input  logic signed [tnst_pkg::RESP_W-1:0] left_value,
   output logic                               stay,
   output logic signed [tnst_pkg::RESP_W-1:0] value
);
   import tnst_pkg::*;

   logic signed [RESP_W-1:0] value_ff;
   logic signed [RESP_W-1:0] value_in;

   assign stay  = cell_valid && (value_ff >= new_value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (shift_en && !stay) begin
         value_in = left_stay ? new_value : left_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[hw/rtl/top_n_sorted_tracker.sv]
// Top level of the top-N sorted tracker: cell row, count, limit and response stage.
//
// Keeps the largest signed responses seen, sorted descending, in a row of
// DEPTH cells. Each request on req_ch carries func (insert, clear, read),
// response and rank_index; each produces exactly one response on rsp_ch
// with kept, entry_count, smallest_kept, read_value and read_valid.
// All cells compare the incoming value at once and shift together, so
// a request is taken every cycle when the response side keeps up.
// A request accept updates the cell row and count and holds the request;
// when it drains, the response register loads from the updated row.
// csr_wr_en/csr_wr_data set the table limit (reset 64, zero acts as one,
// above DEPTH acts as DEPTH); lowering it trims the entry count at once.
// Write it only while no request is in flight.
// Reset empties the table and restores the limit; no clearing pass.
// When rsp_ch stalls, one request is still taken and held; after that
// req_ch.ready drops until the response register drains.
module top_n_sorted_tracker #(
   parameter int DEPTH = tnst_pkg::DEPTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   tnst_req_if.sink                     req_ch,
   tnst_rsp_if.source                   rsp_ch,
   input logic                          csr_wr_en,
   input logic [tnst_pkg::LIMIT_W-1:0]  csr_wr_data
);
   import tnst_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int IW    = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     pend_ff, pend_in;
   func_type                 pfunc_ff;
   logic                     pkept_ff;
   logic [RANK_W-1:0]        pridx_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     kept_ff;
   logic [COUNT_W-1:0]       entry_count_ff;
   logic signed [RESP_W-1:0] smallest_ff, smallest_in;
   logic signed [RESP_W-1:0] read_value_ff, read_value_in;
   logic                     read_valid_ff, read_valid_in;

   logic [CNT_W-1:0]         lim, csr_lim;
   logic                     accept, drain, kept;
   logic                     stay_last;
   func_type                 req_func;
   logic                     shift_en;
   logic [DEPTH-1:0]         stay;
   logic [DEPTH-1:0]         cell_valid;
   logic signed [RESP_W-1:0] cell_value [DEPTH];

   function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] raw);
      logic [CMP_W-1:0] l;
      l = CMP_W'(raw);
      if (raw == '0) begin
         l = CMP_W'(1);
      end
      if (l > CMP_W'(DEPTH)) begin
         l = CMP_W'(DEPTH);
      end
      return CNT_W'(l);
   endfunction

   assign lim      = eff_limit(limit_ff);
   assign csr_lim  = eff_limit(csr_wr_data);
   assign req_func = func_type'(req_ch.func);

   assign drain        = pend_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !pend_ff || drain;
   assign accept       = req_ch.valid && req_ch.ready;

   // hold: insert is kept unless the last allowed rank stays ahead of it
   always_comb begin
      stay_last = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (lim == CNT_W'(i + 1)) begin
            stay_last = stay[i];
         end
      end
   end

   assign kept     = !stay_last;
   assign shift_en = accept && (req_func == FUNC_INSERT) && kept;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      assign cell_valid[g] = count_ff > CNT_W'(g);
      if (g == 0) begin : g_head
         tnst_cell u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .new_value  (req_ch.response),
            .cell_valid (cell_valid[g]),
            .left_stay  (1'b1),
            .left_value (req_ch.response),
            .stay       (stay[g]),
            .value      (cell_value[g])
         );
      end else begin : g_body
         tnst_cell u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .new_value  (req_ch.response),
            .cell_valid (cell_valid[g]),
            .left_stay  (stay[g-1]),
            .left_value (cell_value[g-1]),
            .stay       (stay[g]),
            .value      (cell_value[g])
         );
      end
   end

   always_comb begin
      limit_in = limit_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         limit_in = csr_wr_data;
         if (count_ff > csr_lim) begin
            count_in = csr_lim;
         end
      end else if (accept) begin
         case (req_func)
            FUNC_INSERT: begin
               if (kept && (count_ff < lim)) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FUNC_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (drain) begin
         pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (drain) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      smallest_in   = '0;
      read_value_in = '0;
      read_valid_in = (pfunc_ff == FUNC_READ) && (IW'(pridx_ff) < IW'(count_ff));
      for (int i = 0; i < DEPTH; i++) begin
         if (count_ff == CNT_W'(i + 1)) begin
            smallest_in = cell_value[i];
         end
         if (read_valid_in && (IW'(pridx_ff) == IW'(i))) begin
            read_value_in = cell_value[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pfunc_ff <= req_func;
         pkept_ff <= (req_func == FUNC_INSERT) && kept;
         pridx_ff <= req_ch.rank_index;
      end
      if (drain) begin
         kept_ff        <= pkept_ff;
         entry_count_ff <= COUNT_W'(count_ff);
         smallest_ff    <= smallest_in;
         read_value_ff  <= read_value_in;
         read_valid_ff  <= read_valid_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.kept          = kept_ff;
   assign rsp_ch.entry_count   = entry_count_ff;
   assign rsp_ch.smallest_kept = smallest_ff;
   assign rsp_ch.read_value    = read_value_ff;
   assign rsp_ch.read_valid    = read_valid_ff;

endmodule

[sim/top_n_sorted_tracker_tb.sv]
// Testbench for the top-N sorted tracker: random bursts against a ranked-table predictor.
`timescale 1ns / 100ps

module top_n_sorted_tracker_tb;
   import tnst_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int unsigned TABLE_DEPTH = DEPTH_DEFAULT;
   localparam int unsigned PHASE_ITEMS = 140;
   localparam int unsigned NUM_PHASES = 11;

   typedef struct {
      logic [FUNC_W-1:0]        func;
      logic signed [RESP_W-1:0] response;
      logic [RANK_W-1:0]        rank_index;
   } tracker_req_type;

   typedef struct {
      logic                     kept;
      logic [COUNT_W-1:0]       entry_count;
      logic signed [RESP_W-1:0] smallest_kept;
      logic signed [RESP_W-1:0] read_value;
      logic                     read_valid;
   } tracker_rsp_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   tnst_req_if req_ch ();
   tnst_rsp_if rsp_ch ();

   top_n_sorted_tracker #(
      .DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   tracker_req_type pending_requests[$];
   tracker_rsp_type predicted_responses[$];

   logic signed [RESP_W-1:0] rank_table [TABLE_DEPTH];
   int unsigned rank_count;
   logic [LIMIT_W-1:0] limit_raw;

   int unsigned mismatch_count;
   int unsigned req_accepts;
   int unsigned hold_left;
   int unsigned next_hold_mark;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned stall_mode;
   int unsigned stall_mode_left;

   function automatic int unsigned effective_limit();
      int unsigned lim;
      lim = limit_raw;
      if (lim == 0) lim = 1;
      if (lim > TABLE_DEPTH) lim = TABLE_DEPTH;
      return lim;
   endfunction

   task automatic predict_request(input tracker_req_type req);
      tracker_rsp_type rsp;
      int unsigned lim;
      int unsigned pos;
      int unsigned last;
      rsp.kept = 1'b0;
      rsp.read_value = '0;
      rsp.read_valid = 1'b0;
      rsp.smallest_kept = '0;
      lim = effective_limit();
      case (req.func)
         FUNC_INSERT: begin
            if (rank_count > lim) rank_count = lim;
            pos = 0;
            while (pos < rank_count && rank_table[pos] >= req.response) pos++;
            if (pos < lim) begin
               last = (rank_count < lim) ? rank_count : lim - 1;
               for (int unsigned i = last; i > pos; i--) rank_table[i] = rank_table[i - 1];
               rank_table[pos] = req.response;
               if (rank_count < lim) rank_count++;
               rsp.kept = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            rank_count = 0;
         end
         FUNC_READ: begin
            if (req.rank_index < rank_count) begin
               rsp.read_value = rank_table[req.rank_index];
               rsp.read_valid = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp.entry_count = COUNT_W'(rank_count);
      if (rank_count > 0) rsp.smallest_kept = rank_table[rank_count - 1];
      predicted_responses.push_back(rsp);
   endtask

   function automatic logic signed [RESP_W-1:0] random_response();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return $urandom;
      if (pick < 7) return $signed($urandom_range(0, 16)) - 8;
      if (pick < 8) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            default: return -1;
         endcase
      end
      return $signed($urandom_range(0, 1000)) - 500;
   endfunction

   function automatic tracker_req_type random_request(input int unsigned clear_pm);
      tracker_req_type req;
      int unsigned pick;
      pick = $urandom_range(0, 999);
      req.response = random_response();
      req.rank_index = $urandom_range(0, 1) ? RANK_W'($urandom_range(0, 63))
                                            : RANK_W'($urandom_range(0, 7));
      if (pick < clear_pm) req.func = FUNC_CLEAR;
      else if (pick < clear_pm + 150) req.func = FUNC_READ;
      else if (pick < clear_pm + 170) req.func = FUNC_UNUSED;
      else req.func = FUNC_INSERT;
      return req;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick < 3) return 0;
      if (pick < 6) return $urandom_range(1, 4);
      if (pick < 7) return $urandom_range(5, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic push_request(input logic [FUNC_W-1:0] func,
                               input logic signed [RESP_W-1:0] response,
                               input logic [RANK_W-1:0] rank_index);
      tracker_req_type req;
      req.func = func;
      req.response = response;
      req.rank_index = rank_index;
      pending_requests.push_back(req);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || predicted_responses.size() != 0) @(negedge clock);
   endtask

   task automatic write_table_limit(input logic [LIMIT_W-1:0] value);
      int unsigned lim;
      wait_drained();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_raw = value;
      lim = effective_limit();
      if (rank_count > lim) rank_count = lim;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // request driver: bursts with random gaps, hold valid until accepted
   always @(posedge clock) begin
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_request(pending_requests.pop_front());
            req_accepts <= req_accepts + 1;
         end else if (req_ch.valid) begin
            offer = 1'b1;
         end
         if (!offer) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_requests.size() != 0) begin
               offer = 1'b1;
               if (burst_left == 0) burst_left = $urandom_range(1, 48);
               burst_left--;
               if (burst_left == 0) gap_left = pick_gap();
            end
         end
         req_ch.valid <= offer;
         if (offer) begin
            req_ch.func <= pending_requests[0].func;
            req_ch.response <= pending_requests[0].response;
            req_ch.rank_index <= pending_requests[0].rank_index;
         end
      end
   end

   // long receiver hold-off, started at request-count marks
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         next_hold_mark <= 300;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (req_accepts >= next_hold_mark) begin
         hold_left <= $urandom_range(150, 300);
         next_hold_mark <= next_hold_mark + 450;
      end
   end

   // response monitor: check against the oldest prediction, stall on its own pattern
   always @(posedge clock) begin
      tracker_rsp_type want;
      logic take;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_mode = 0;
         stall_mode_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: count %0d smallest %0d",
                           rsp_ch.entry_count, rsp_ch.smallest_kept);
            end else begin
               want = predicted_responses.pop_front();
               if (rsp_ch.kept !== want.kept || rsp_ch.entry_count !== want.entry_count ||
                   rsp_ch.smallest_kept !== want.smallest_kept ||
                   rsp_ch.read_value !== want.read_value ||
                   rsp_ch.read_valid !== want.read_valid) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected kept %0d count %0d smallest %0d ",
                               "read %0d/%0d, got kept %0d count %0d smallest %0d ",
                               "read %0d/%0d"},
                              want.kept, want.entry_count, want.smallest_kept,
                              want.read_value, want.read_valid,
                              rsp_ch.kept, rsp_ch.entry_count, rsp_ch.smallest_kept,
                              rsp_ch.read_value, rsp_ch.read_valid);
               end
            end
         end
         if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(16, 96);
         end
         stall_mode_left--;
         case (stall_mode)
            0: take = 1'b1;
            1: take = $urandom_range(0, 1);
            2: take = ($urandom_range(0, 3) == 0);
            default: take = ($urandom_range(0, 7) != 0);
         endcase
         rsp_ch.ready <= take && (hold_left == 0);
      end
   end

   initial begin
      logic [LIMIT_W-1:0] phase_limits [NUM_PHASES];
      logic [LIMIT_W-1:0] lim_value;
      int unsigned clear_pm;
      phase_limits = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd17, 7'd0, 7'd63, 7'd100, 7'd64, 7'd4, 7'd64};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.func = '0;
      req_ch.response = '0;
      req_ch.rank_index = '0;
      rsp_ch.ready = 1'b0;
      rank_count = 0;
      limit_raw = LIMIT_RESET;
      mismatch_count = 0;
      req_accepts = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, extremes, duplicates, reads in and out of range
      push_request(FUNC_READ, 0, 0);
      push_request(FUNC_UNUSED, 32'sh12345678, 6'd63);
      push_request(FUNC_INSERT, 32'sh7fffffff, 0);
      push_request(FUNC_INSERT, 32'sh80000000, 0);
      push_request(FUNC_INSERT, 0, 0);
      push_request(FUNC_INSERT, 0, 0);
      push_request(FUNC_INSERT, -1, 0);
      push_request(FUNC_READ, 0, 0);
      push_request(FUNC_READ, 0, 4);
      push_request(FUNC_READ, 0, 5);
      push_request(FUNC_READ, -1, 6'd63);
      push_request(FUNC_CLEAR, -1, 6'd63);
      push_request(FUNC_READ, 0, 0);

      // one-entry table: equal to smallest dropped, larger replaces
      write_table_limit(7'd1);
      push_request(FUNC_INSERT, 5, 0);
      push_request(FUNC_INSERT, 5, 0);
      push_request(FUNC_INSERT, 7, 0);
      push_request(FUNC_INSERT, -3, 0);
      push_request(FUNC_READ, 0, 0);

      // zero limit acts as one
      write_table_limit(7'd0);
      push_request(FUNC_INSERT, 32'sh80000000, 0);
      push_request(FUNC_INSERT, 32'sh7fffffff, 0);
      push_request(FUNC_READ, 0, 0);

      // limit above depth, then lower below the count to trim
      write_table_limit(7'd127);
      push_request(FUNC_INSERT, 100, 0);
      push_request(FUNC_INSERT, -100, 0);
      push_request(FUNC_INSERT, 2, 0);
      write_table_limit(7'd2);
      push_request(FUNC_READ, 0, 1);
      push_request(FUNC_READ, 0, 2);

      for (int p = 0; p < NUM_PHASES; p++) begin
         lim_value = (p == 8) ? LIMIT_W'($urandom_range(1, 64)) : phase_limits[p];
         write_table_limit(lim_value);
         clear_pm = (lim_value >= 32) ? 5 : 40;
         repeat (PHASE_ITEMS) pending_requests.push_back(random_request(clear_pm));
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && predicted_responses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/tnst_pkg.sv
hw/rtl/tnst_ifs.sv
hw/rtl/tnst_cell.sv
hw/rtl/top_n_sorted_tracker.sv
sim/top_n_sorted_tracker_tb.sv
